### rtl/ssl_pkg.sv
// Shared constants, codes and types for the shortest supersequence length block.
// No dependencies; every other file in rtl/ imports this package.
package ssl_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int LEN_W   = 12;
    localparam int KIND_W  = 2;
    localparam int SYM_W   = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRST   = 2'd0,
        KIND_SECOND  = 2'd1,
        KIND_COMPUTE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_READ,
        S_CALC,
        S_DONE
    } t_state;

    // Sequencer to cell unit: one address serves the init write, the read and the update.
    typedef struct packed {
        logic              init_wr;
        logic              row_start;
        logic              calc;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  value;
    } t_cell_ctl;

endpackage

### rtl/ssl_text_mem.sv
// Symbol store for one string: one write port, one read port, registered read data.
// Depends on ssl_pkg.
module ssl_text_mem
    import ssl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [SYM_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [SYM_W-1:0]  o_rd_data
);

    logic [SYM_W-1:0] r_mem [MAX_LEN];
    logic [SYM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ssl_cell_unit.sv
// Cost row store and the shared cell unit: compare, minimum and increment.
// Depends on ssl_pkg (t_cell_ctl, widths).
module ssl_cell_unit
    import ssl_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [SYM_W-1:0] i_sym_a,
    input  logic [SYM_W-1:0] i_sym_b,
    output logic [LEN_W-1:0] o_last
);

    logic [LEN_W-1:0] r_mem [MAX_LEN];
    logic [LEN_W-1:0] r_below;
    logic [LEN_W-1:0] r_diag;
    logic [LEN_W-1:0] r_right;
    logic [LEN_W-1:0] n_cell;
    logic [LEN_W-1:0] w_min;

    // match takes the diagonal, mismatch the smaller neighbour
    always_comb begin
        w_min  = (r_below < r_right) ? r_below : r_right;
        n_cell = (i_sym_a == i_sym_b) ? r_diag + LEN_W'(1) : w_min + LEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init_wr) begin
            r_mem[i_ctl.addr] <= i_ctl.value;
        end else if (i_ctl.calc) begin
            r_mem[i_ctl.addr] <= n_cell;
        end
        r_below <= r_mem[i_ctl.addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_start) begin
            r_diag  <= i_ctl.value;
            r_right <= i_ctl.value + LEN_W'(1);
        end else if (i_ctl.calc) begin
            r_diag  <= r_below;
            r_right <= n_cell;
        end
    end

    assign o_last = r_right;

endmodule

### rtl/shortest_supersequence_length.sv
// Top level: load sequencer, compute sequencer and result register.
// Depends on ssl_pkg, ssl_text_mem and ssl_cell_unit.
//
//  channel | valid       | ready       | payload
//  input   | i_in_valid  | o_in_ready  | i_kind, i_symbol
//  output  | o_out_valid | i_out_ready | o_super_length, o_overflowed
//
// Symbol words are taken without leaving idle; ready stays high between computes.
// A compute word seeds the cost row from the second string, then for each row of the
// first string starts the row and walks its cells (a cost row read, then an update)
// through the single cell unit and cost row port.
// With either string empty the result is the sum of both lengths, with no row pass.
// Reset clears both lengths, the drop flag and the result valid flag; stores are not cleared.
// The result register frees the input side: loads proceed while a result waits.
module shortest_supersequence_length
    import ssl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [LEN_W-1:0]  o_super_length,
    output logic              o_overflowed
);

    t_state           r_state;
    t_state           n_state;
    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] r_first_count;
    logic [CNT_W-1:0] r_second_count;
    logic             r_drop;
    logic [ADDR_W-1:0] r_row;
    logic [ADDR_W-1:0] r_col;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_super_length;
    logic             r_overflowed;

    logic             w_accept;
    logic             w_first_full;
    logic             w_second_full;
    logic             w_wr_first;
    logic             w_wr_second;
    logic             w_empty;
    logic             w_slot_free;
    logic [ADDR_W-1:0] w_n_last;
    logic [ADDR_W-1:0] w_m_last;
    logic [SYM_W-1:0] w_sym_a;
    logic [SYM_W-1:0] w_sym_b;
    logic [LEN_W-1:0] w_last;

    assign w_accept      = i_in_valid && o_in_ready;
    assign w_first_full  = (r_first_count == CNT_W'(MAX_LEN));
    assign w_second_full = (r_second_count == CNT_W'(MAX_LEN));
    assign w_wr_first    = w_accept && (i_kind == KIND_FIRST) && !w_first_full;
    assign w_wr_second   = w_accept && (i_kind == KIND_SECOND) && !w_second_full;
    assign w_empty       = (r_first_count == '0) || (r_second_count == '0);
    assign w_slot_free   = !r_out_valid || i_out_ready;
    assign w_n_last      = ADDR_W'(r_first_count - CNT_W'(1));
    assign w_m_last      = ADDR_W'(r_second_count - CNT_W'(1));

    ssl_text_mem u_first_text (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_first),
        .i_wr_addr (r_first_count[ADDR_W-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_addr (r_row),
        .o_rd_data (w_sym_a)
    );

    ssl_text_mem u_second_text (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_second),
        .i_wr_addr (r_second_count[ADDR_W-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_addr (r_col),
        .o_rd_data (w_sym_b)
    );

    ssl_cell_unit u_cell (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sym_a (w_sym_a),
        .i_sym_b (w_sym_b),
        .o_last  (w_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = (r_state == S_IDLE);
        w_ctl        = '0;
        w_ctl.addr   = r_col;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_kind == KIND_COMPUTE)) begin
                    n_state = w_empty ? S_DONE : S_INIT;
                end
            end
            S_INIT: begin
                // seed the row with the symbols left in the second string
                w_ctl.init_wr = 1'b1;
                w_ctl.value   = LEN_W'(r_second_count) - LEN_W'(r_col);
                if (r_col == w_m_last) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                // edge cells of this row follow from the first string's remainder
                w_ctl.row_start = 1'b1;
                w_ctl.value     = LEN_W'(r_first_count) - LEN_W'(r_row) - LEN_W'(1);
                n_state         = S_READ;
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                w_ctl.calc = 1'b1;
                if (r_col == '0) begin
                    n_state = (r_row == '0) ? S_DONE : S_ROW;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count  <= '0;
            r_second_count <= '0;
            r_drop         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_kind)
                            KIND_FIRST: begin
                                if (w_first_full) begin
                                    r_drop <= 1'b1;
                                end else begin
                                    r_first_count <= r_first_count + CNT_W'(1);
                                end
                            end
                            KIND_SECOND: begin
                                if (w_second_full) begin
                                    r_drop <= 1'b1;
                                end else begin
                                    r_second_count <= r_second_count + CNT_W'(1);
                                end
                            end
                            KIND_COMPUTE: begin
                                r_col <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    if (r_col == w_m_last) begin
                        r_row <= w_n_last;
                    end else begin
                        r_col <= r_col + ADDR_W'(1);
                    end
                end
                S_ROW: begin
                    r_col <= w_m_last;
                end
                S_READ: begin
                end
                S_CALC: begin
                    if (r_col == '0) begin
                        if (r_row != '0) begin
                            r_row <= r_row - ADDR_W'(1);
                        end
                    end else begin
                        r_col <= r_col - ADDR_W'(1);
                    end
                end
                S_DONE: begin
                    // hand over the word, then drop both strings and the flag
                    if (w_slot_free) begin
                        r_out_valid    <= 1'b1;
                        r_super_length <= w_empty
                            ? LEN_W'(r_first_count) + LEN_W'(r_second_count) : w_last;
                        r_overflowed   <= r_drop;
                        r_first_count  <= '0;
                        r_second_count <= '0;
                        r_drop         <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_super_length = r_super_length;
    assign o_overflowed   = r_overflowed;

endmodule
